>>> hw/rtl/mlk_pkg.sv
// ----------------------------------------------------------------------------
// mlk_pkg
// Shared types, constants and the letter table of the Morse letter keyer.
// ----------------------------------------------------------------------------
package mlk_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned CFG_WIDTH       = 16;
  localparam int unsigned CFG_IDX_WIDTH   = 2;

  localparam logic [CFG_WIDTH-1:0] DOT_TICKS_RST    = 16'd120;
  localparam logic [CFG_WIDTH-1:0] DASH_TICKS_RST   = 16'd360;
  localparam logic [CFG_WIDTH-1:0] EGAP_TICKS_RST   = 16'd120;
  localparam logic [CFG_WIDTH-1:0] LGAP_TICKS_RST   = 16'd840;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_DOT_TICKS  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DASH_TICKS = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_EGAP_TICKS = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LGAP_TICKS = 2'd3;

  localparam logic [7:0] CHAR_A = 8'd65;
  localparam logic [7:0] CHAR_Z = 8'd90;

  typedef struct packed {
    logic       is_tick;
    logic       code_ok;
    logic [3:0] kinds;
    logic [2:0] total;
  } mlk_item_t;

  localparam int unsigned ITEM_WIDTH = $bits(mlk_item_t);

  // element count in [6:4], dash flags in [3:0]
  function automatic logic [6:0] letter_code(input logic [4:0] idx);
    logic [6:0] c;
    case (idx)
      5'd0:    c = 7'h22;
      5'd1:    c = 7'h41;
      5'd2:    c = 7'h45;
      5'd3:    c = 7'h31;
      5'd4:    c = 7'h10;
      5'd5:    c = 7'h44;
      5'd6:    c = 7'h33;
      5'd7:    c = 7'h40;
      5'd8:    c = 7'h20;
      5'd9:    c = 7'h4E;
      5'd10:   c = 7'h35;
      5'd11:   c = 7'h42;
      5'd12:   c = 7'h23;
      5'd13:   c = 7'h21;
      5'd14:   c = 7'h37;
      5'd15:   c = 7'h46;
      5'd16:   c = 7'h4B;
      5'd17:   c = 7'h32;
      5'd18:   c = 7'h30;
      5'd19:   c = 7'h11;
      5'd20:   c = 7'h34;
      5'd21:   c = 7'h48;
      5'd22:   c = 7'h36;
      5'd23:   c = 7'h49;
      5'd24:   c = 7'h4D;
      5'd25:   c = 7'h43;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/morse_letter_keyer.sv
// ----------------------------------------------------------------------------
// morse_letter_keyer
// Morse keyer: takes ticks and letters, drives the key line per letter.
// ----------------------------------------------------------------------------
// Path: each accepted word passes the queue and then the result register;
//   a stalled result side holds later words back in the queue.
// Throughput: one word per cycle while the result side is not stalled, set by
//   the sequencer update in the back end fed from a two-entry queue.
// Reset: asynchronous, active low; sequencer idle, its key line off, timing
//   registers at dot 120, dash 360, element gap 120, letter gap 840 ticks.
// ----------------------------------------------------------------------------
module morse_letter_keyer import mlk_pkg::*; #(
  parameter int unsigned CountWidth = COUNT_WIDTH_DEF,
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [7:0]               char_code_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     key_on_o,
  output logic                     busy_res_o,
  output logic                     accepted_o,
  output logic                     rejected_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]     cfg_data_i
);

  mlk_item_t push_item, head_item;
  logic      push, pop, q_full, q_empty;

  mlk_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .char_code_i (char_code_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  mlk_queue #(
    .Width (ITEM_WIDTH),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .pop_i   (pop),
    .data_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mlk_back #(
    .CountWidth (CountWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (head_item),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_on_o    (key_on_o),
    .busy_res_o  (busy_res_o),
    .accepted_o  (accepted_o),
    .rejected_o  (rejected_o)
  );

endmodule

>>> hw/rtl/mlk_front.sv
// ----------------------------------------------------------------------------
// mlk_front
// Input side: accepts words, classifies tick or letter and looks up the code.
// ----------------------------------------------------------------------------
module mlk_front import mlk_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] char_code_i,
  input  logic       q_full_i,
  output logic       push_o,
  output mlk_item_t  item_o
);

  logic       in_range;
  logic [7:0] offs;
  logic [6:0] code;

  assign in_range   = (char_code_i >= CHAR_A) && (char_code_i <= CHAR_Z);
  assign offs       = char_code_i - CHAR_A;
  assign code       = letter_code(offs[4:0]);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.is_tick = !action_i;
    item_o.code_ok = in_range;
    item_o.kinds   = code[3:0];
    item_o.total   = code[6:4];
  end

endmodule

>>> hw/rtl/mlk_queue.sv
// ----------------------------------------------------------------------------
// mlk_queue
// Short register queue between front and back end.
// ----------------------------------------------------------------------------
module mlk_queue import mlk_pkg::*; #(
  parameter int unsigned Width = ITEM_WIDTH,
  parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/mlk_back.sv
// ----------------------------------------------------------------------------
// mlk_back
// Execution side: timing registers, element sequencer and result register.
// ----------------------------------------------------------------------------
module mlk_back import mlk_pkg::*; #(
  parameter int unsigned CountWidth = COUNT_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]     cfg_data_i,
  input  mlk_item_t                item_i,
  input  logic                     q_empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     key_on_o,
  output logic                     busy_res_o,
  output logic                     accepted_o,
  output logic                     rejected_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MARK = 2'd1,
    PH_EGAP = 2'd2,
    PH_LGAP = 2'd3
  } phase_e;

  logic [CFG_WIDTH-1:0]  dot_q, dash_q, egap_q, lgap_q;
  phase_e                phase_q, phase_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [3:0]            kinds_q, kinds_d;
  logic [2:0]            total_q, total_d;
  logic [2:0]            pos_q, pos_d, pos_inc;
  logic                  line_q, line_d;
  logic                  acc_d, rej_d;
  logic                  out_valid_q, key_q, busy_q, acc_q, rej_q;

  function automatic logic [CountWidth-1:0] clamp_cnt(input logic [CFG_WIDTH-1:0] v);
    logic [32:0] lim;
    lim = (33'd1 << CountWidth) - 33'd1;
    if ({{(33 - CFG_WIDTH){1'b0}}, v} > lim) begin
      clamp_cnt = '1;
    end else begin
      clamp_cnt = CountWidth'(v);
    end
  endfunction

  assign pop_o   = !q_empty_i && (!out_valid_q || out_ready_i);
  assign pos_inc = pos_q + 3'd1;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    kinds_d = kinds_q;
    total_d = total_q;
    pos_d   = pos_q;
    line_d  = line_q;
    acc_d   = 1'b0;
    rej_d   = 1'b0;
    if (item_i.is_tick) begin
      if (phase_q != PH_IDLE) begin
        if (cnt_q > CountWidth'(1)) begin
          cnt_d = cnt_q - CountWidth'(1);
        end else begin
          cnt_d = '0;
          case (phase_q)
            PH_MARK: begin
              phase_d = PH_EGAP;
              line_d  = 1'b0;
              cnt_d   = clamp_cnt(egap_q);
            end
            PH_EGAP: begin
              pos_d = pos_inc;
              if (pos_inc < total_q) begin
                phase_d = PH_MARK;
                line_d  = 1'b1;
                cnt_d   = clamp_cnt(kinds_q[pos_inc[1:0]] ? dash_q : dot_q);
              end else if (lgap_q != '0) begin
                phase_d = PH_LGAP;
                cnt_d   = clamp_cnt(lgap_q);
              end else begin
                phase_d = PH_IDLE;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
    end else if (phase_q != PH_IDLE || !item_i.code_ok) begin
      rej_d = 1'b1;
    end else begin
      kinds_d = item_i.kinds;
      total_d = item_i.total;
      pos_d   = 3'd0;
      phase_d = PH_MARK;
      line_d  = 1'b1;
      cnt_d   = clamp_cnt(item_i.kinds[0] ? dash_q : dot_q);
      acc_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q  <= DOT_TICKS_RST;
      dash_q <= DASH_TICKS_RST;
      egap_q <= EGAP_TICKS_RST;
      lgap_q <= LGAP_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DOT_TICKS:  dot_q  <= cfg_data_i;
        REG_DASH_TICKS: dash_q <= cfg_data_i;
        REG_EGAP_TICKS: egap_q <= cfg_data_i;
        REG_LGAP_TICKS: lgap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      kinds_q     <= '0;
      total_q     <= '0;
      pos_q       <= '0;
      line_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        kinds_q <= kinds_d;
        total_q <= total_d;
        pos_q   <= pos_d;
        line_q  <= line_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      key_q  <= line_d;
      busy_q <= (phase_d != PH_IDLE);
      acc_q  <= acc_d;
      rej_q  <= rej_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_on_o    = key_q;
  assign busy_res_o  = busy_q;
  assign accepted_o  = acc_q;
  assign rejected_o  = rej_q;

  a_line_tracks_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q == (phase_q == PH_MARK))
    else $error("key line out of step with phase");

  a_acc_rej_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(acc_q && rej_q))
    else $error("word both accepted and rejected");

  a_key_implies_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && key_q |-> busy_q)
    else $error("key on while not busy");

  a_accept_from_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && acc_d |-> phase_q == PH_IDLE)
    else $error("letter taken while busy");

endmodule

>>> sim/morse_keyer_checker.sv
// ----------------------------------------------------------------------------
// morse_keyer_checker
// Watches the word channels of the Morse letter keyer, keeps its own copy of
// the timing registers and the letter sequencer, predicts the key line,
// busy, accepted and rejected flags for every accepted word and compares
// them with the results as they leave the block.
// ----------------------------------------------------------------------------
module morse_keyer_checker import mlk_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     action_i,
  input  logic [7:0]               char_code_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic                     key_on_i,
  input  logic                     busy_res_i,
  input  logic                     accepted_i,
  input  logic                     rejected_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]     cfg_data_i,
  output int                       mismatch_count_o,
  output int                       results_due_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    KEY_IDLE,
    KEY_MARK,
    KEY_EGAP,
    KEY_LGAP
  } key_phase_e;

  typedef struct packed {
    logic key_on;
    logic busy;
    logic accepted;
    logic rejected;
  } key_result_t;

  logic [15:0] dot_len;
  logic [15:0] dash_len;
  logic [15:0] egap_len;
  logic [15:0] lgap_len;

  logic [3:0]  kinds;
  logic [2:0]  total;
  logic [2:0]  pos;
  key_phase_e  ph;
  logic [15:0] cnt;
  logic        line;

  key_result_t key_results_due[$];
  key_result_t due;
  int          mismatches;
  int          pending;

  assign mismatch_count_o = mismatches;
  assign results_due_o    = pending;

  function automatic string morse_pattern(input logic [4:0] idx);
    case (idx)
      5'd0:    return ".-";
      5'd1:    return "-...";
      5'd2:    return "-.-.";
      5'd3:    return "-..";
      5'd4:    return ".";
      5'd5:    return "..-.";
      5'd6:    return "--.";
      5'd7:    return "....";
      5'd8:    return "..";
      5'd9:    return ".---";
      5'd10:   return "-.-";
      5'd11:   return ".-..";
      5'd12:   return "--";
      5'd13:   return "-.";
      5'd14:   return "---";
      5'd15:   return ".--.";
      5'd16:   return "--.-";
      5'd17:   return ".-.";
      5'd18:   return "...";
      5'd19:   return "-";
      5'd20:   return "..-";
      5'd21:   return "...-";
      5'd22:   return ".--";
      5'd23:   return "-..-";
      5'd24:   return "-.--";
      5'd25:   return "--..";
      default: return "";
    endcase
  endfunction

  function automatic void start_element();
    ph   = KEY_MARK;
    line = 1'b1;
    cnt  = kinds[pos[1:0]] ? dash_len : dot_len;
  endfunction

  function automatic key_result_t key_line_step(input logic act, input logic [7:0] ch);
    key_result_t r;
    string       pat;
    logic [7:0]  idx;
    r = '0;
    if (!act) begin
      if (ph != KEY_IDLE) begin
        if (cnt > 16'd1) begin
          cnt = cnt - 16'd1;
        end else begin
          cnt = '0;
          case (ph)
            KEY_MARK: begin
              ph   = KEY_EGAP;
              line = 1'b0;
              cnt  = egap_len;
            end
            KEY_EGAP: begin
              pos = pos + 3'd1;
              if (pos < total) begin
                start_element();
              end else if (lgap_len != '0) begin
                ph  = KEY_LGAP;
                cnt = lgap_len;
              end else begin
                ph = KEY_IDLE;
              end
            end
            default: ph = KEY_IDLE;
          endcase
        end
      end
    end else if (ph != KEY_IDLE || ch < CHAR_A || ch > CHAR_Z) begin
      r.rejected = 1'b1;
    end else begin
      idx   = ch - CHAR_A;
      pat   = morse_pattern(idx[4:0]);
      total = 3'(pat.len());
      kinds = '0;
      for (int i = 0; i < pat.len(); i++) kinds[i] = (pat[i] == "-");
      pos = '0;
      start_element();
      r.accepted = 1'b1;
    end
    r.key_on = line;
    r.busy   = (ph != KEY_IDLE);
    return r;
  endfunction

  task automatic check_flag(input string name, input logic exp_v, input logic act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_len  = DOT_TICKS_RST;
      dash_len = DASH_TICKS_RST;
      egap_len = EGAP_TICKS_RST;
      lgap_len = LGAP_TICKS_RST;
      kinds    = '0;
      total    = '0;
      pos      = '0;
      ph       = KEY_IDLE;
      cnt      = '0;
      line     = 1'b0;
      key_results_due.delete();
      mismatches = 0;
      pending    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DOT_TICKS:  dot_len  = cfg_data_i;
          REG_DASH_TICKS: dash_len = cfg_data_i;
          REG_EGAP_TICKS: egap_len = cfg_data_i;
          REG_LGAP_TICKS: lgap_len = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (key_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual key %0b busy %0b acc %0b rej %0b",
                   $time, key_on_i, busy_res_i, accepted_i, rejected_i);
          mismatches++;
        end else begin
          due = key_results_due.pop_front();
          check_flag("key_on", due.key_on, key_on_i);
          check_flag("busy_res", due.busy, busy_res_i);
          check_flag("accepted", due.accepted, accepted_i);
          check_flag("rejected", due.rejected, rejected_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        key_results_due.push_back(key_line_step(action_i, char_code_i));
      end
      pending = key_results_due.size();
    end
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives ticks and letter offers into the Morse letter keyer under random
// idling on both sides, rewrites the timing registers between phases (zero,
// one, small random and full-scale times) and leaves the prediction and
// comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;

  import mlk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_WORDS    = 215;
  localparam int RANDOM_PHASES  = 6;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     action = 1'b0;
  logic [7:0]               char_code = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     key_on;
  logic                     busy_res;
  logic                     accepted;
  logic                     rejected;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx = REG_DOT_TICKS;
  logic [CFG_WIDTH-1:0]     cfg_data = '0;

  int mismatch_count;
  int results_due;
  bit idle_on = 1'b1;
  int hold_req = 0;

  always #5 clk = ~clk;

  morse_letter_keyer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .char_code_i (char_code),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .key_on_o    (key_on),
    .busy_res_o  (busy_res),
    .accepted_o  (accepted),
    .rejected_o  (rejected),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  morse_keyer_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .action_i         (action),
    .char_code_i      (char_code),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .key_on_i         (key_on),
    .busy_res_i       (busy_res),
    .accepted_i       (accepted),
    .rejected_i       (rejected),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .results_due_o    (results_due)
  );

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= !(idle_on && $urandom_range(0, 99) < 23);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_word(input logic act, input logic [7:0] ch);
    while (idle_on && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    char_code <= ch;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_timing(input logic [15:0] dot, input logic [15:0] dash,
                              input logic [15:0] egap, input logic [15:0] lgap);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_DOT_TICKS;
    cfg_data <= dot;
    @(negedge clk);
    cfg_idx  <= REG_DASH_TICKS;
    cfg_data <= dash;
    @(negedge clk);
    cfg_idx  <= REG_EGAP_TICKS;
    cfg_data <= egap;
    @(negedge clk);
    cfg_idx  <= REG_LGAP_TICKS;
    cfg_data <= lgap;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [15:0] pick_len(input int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 16'd0;
    if (r < 24) return 16'd1;
    return 16'($urandom_range(1, hi));
  endfunction

  task automatic random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) send_word(1'b0, 8'($urandom_range(0, 255)));
    else if (r < 92) send_word(1'b1, 8'($urandom_range(CHAR_A, CHAR_Z)));
    else send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int hi;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // out-of-range codes, idle tick, busy offer at reset timing
    send_word(1'b0, 8'hFF);
    send_word(1'b1, 8'h00);
    send_word(1'b1, 8'hFF);
    send_word(1'b1, CHAR_A - 8'd1);
    send_word(1'b1, CHAR_Z + 8'd1);
    send_word(1'b1, CHAR_A);
    send_word(1'b1, CHAR_Z);
    repeat (3) send_word(1'b0, 8'h00);
    drain();

    // zero times: every part lasts one tick, no letter gap
    write_timing(16'd0, 16'd0, 16'd0, 16'd0);
    send_word(1'b1, "E");
    repeat (2) send_word(1'b0, 8'h55);
    send_word(1'b1, "T");
    repeat (2) send_word(1'b0, 8'hAA);
    send_word(1'b1, "Q");
    repeat (9) send_word(1'b0, 8'h00);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      hi = (p == 5) ? 40 : 5;
      case (p)
        3:       write_timing(16'd0, 16'd0, 16'd0, 16'd0);
        4:       write_timing(16'd1, 16'd1, 16'd1, 16'd1);
        default: write_timing(pick_len(hi), pick_len(hi), pick_len(hi), pick_len(2 * hi));
      endcase
      idle_on = (p != 1);
      if (p == 2) hold_req++;
      repeat (PHASE_WORDS) random_word();
      drain();
    end
    idle_on = 1'b1;

    // full-scale times: long parts, letters offered while busy
    write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(1'b1, "E");
    for (int i = 0; i < 40; i++) begin
      if (i % 8 == 7) send_word(1'b1, 8'($urandom_range(CHAR_A, CHAR_Z)));
      else send_word(1'b0, 8'($urandom_range(0, 255)));
    end
    send_word(1'b1, "Z");
    send_word(1'b0, 8'h00);
    drain();

    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
